// File: design/mm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared widths, register indexes, control structs and helpers.
// ----------------------------------------------------------------------------
package mm_pkg;

	// Fixed payload widths
	localparam int VALUE_W    = 16;
	localparam int PRODUCT_W  = 35;
	localparam int IDX_W      = 3;
	localparam int DIM_CFG_W  = 4;

	// Configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_LEFT_ROWS  = 2'd0;
	localparam logic [1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [1:0] REG_RIGHT_COLS = 2'd2;

	// Element input codes
	localparam logic OP_LEFT  = 1'b0;
	localparam logic OP_RIGHT = 1'b1;

	// Matrix dimensions, already clamped to 1..MAX_DIM
	typedef struct packed {
		logic [DIM_CFG_W-1:0] rows;
		logic [DIM_CFG_W-1:0] inner;
		logic [DIM_CFG_W-1:0] cols;
	} mm_cfg_t;

	// One multiply-accumulate beat travelling down the pipeline
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             fin;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} mm_tok_t;

	// Map a written dimension into 1..lim
	function automatic logic [DIM_CFG_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v,
		input logic [DIM_CFG_W-1:0] lim);
		logic [DIM_CFG_W-1:0] d;
		d = v;
		if (d == '0) begin
			d = DIM_CFG_W'(1);
		end
		if (d > lim) begin
			d = lim;
		end
		return d;
	endfunction

endpackage

// File: design/mm_if.sv
// ----------------------------------------------------------------------------
// Matrix multiply channels
// Valid/ready channels for loaded elements and product elements.
// ----------------------------------------------------------------------------
interface mm_in_if;
	import mm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic signed [VALUE_W-1:0] value;

	modport source(output valid, output operation, output value, input ready);
	modport sink(input valid, input operation, input value, output ready);
endinterface

interface mm_out_if;
	import mm_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [PRODUCT_W-1:0] product;
	logic [IDX_W-1:0]            out_row;
	logic [IDX_W-1:0]            out_col;
	logic                        last;

	modport source(output valid, output product, output out_row, output out_col,
		output last, input ready);
	modport sink(input valid, input product, input out_row, input out_col,
		input last, output ready);
endinterface

// File: design/mm_regs.sv
// ----------------------------------------------------------------------------
// Matrix multiply registers
// APB-style register file holding the three matrix dimensions.
// ----------------------------------------------------------------------------
module mm_regs #(
	parameter int MAX_DIM = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mm_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	output mm_pkg::mm_cfg_t               cfg
);
	import mm_pkg::*;

	logic                 wr_en;
	logic [1:0]           reg_idx;
	logic [DIM_CFG_W-1:0] wr_dim;
	mm_cfg_t              cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign wr_dim  = clamp_dim(pwdata[DIM_CFG_W-1:0], DIM_CFG_W'(MAX_DIM));

	// Write one dimension at the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows  <= DIM_CFG_W'(1);
			cfg_q.inner <= DIM_CFG_W'(1);
			cfg_q.cols  <= DIM_CFG_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_LEFT_ROWS:  cfg_q.rows  <= wr_dim;
				REG_INNER_SIZE: cfg_q.inner <= wr_dim;
				REG_RIGHT_COLS: cfg_q.cols  <= wr_dim;
				default: ;
			endcase
		end
	end

	// Read back the stored dimension
	always_comb begin
		case (reg_idx)
			REG_LEFT_ROWS:  prdata = APB_DATA_W'(cfg_q.rows);
			REG_INNER_SIZE: prdata = APB_DATA_W'(cfg_q.inner);
			REG_RIGHT_COLS: prdata = APB_DATA_W'(cfg_q.cols);
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: design/mm_seq.sv
// ----------------------------------------------------------------------------
// Matrix multiply sequencer
// Counts loaded elements and walks row, inner and column indexes.
// ----------------------------------------------------------------------------
module mm_seq #(
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mm_pkg::mm_cfg_t   cfg,
	input  logic              fire,
	input  logic              op,
	input  logic              adv,
	input  logic              drain_busy,
	output logic              ready,
	output logic              wr_left,
	output logic              wr_right,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [ADDR_W-1:0] laddr,
	output logic [ADDR_W-1:0] raddr,
	output mm_pkg::mm_tok_t   issue
);
	import mm_pkg::*;

	localparam int CNT_W = ADDR_W + 1;

	logic [CNT_W-1:0]  lcnt_q, rcnt_q, lcnt_nxt, rcnt_nxt;
	logic [7:0]        need_l, need_r;
	logic              done;
	logic              run_q;
	logic [IDX_W-1:0]  r_q, k_q, c_q;
	logic [IDX_W-1:0]  rows_m1, inner_m1, cols_m1;
	logic [ADDR_W-1:0] laddr_q, raddr_q;
	logic              c_wrap, k_wrap, r_wrap;

	assign need_l = {4'd0, cfg.rows} * {4'd0, cfg.inner};
	assign need_r = {4'd0, cfg.inner} * {4'd0, cfg.cols};

	// Drop elements for a matrix that is already complete
	assign wr_left  = fire && (op == OP_LEFT) && (8'(lcnt_q) < need_l);
	assign wr_right = fire && (op == OP_RIGHT) && (8'(rcnt_q) < need_r);
	assign wr_addr  = wr_left ? lcnt_q[ADDR_W-1:0] : rcnt_q[ADDR_W-1:0];

	assign lcnt_nxt = lcnt_q + CNT_W'(wr_left);
	assign rcnt_nxt = rcnt_q + CNT_W'(wr_right);
	assign done     = (8'(lcnt_nxt) >= need_l) && (8'(rcnt_nxt) >= need_r);

	assign rows_m1  = IDX_W'(cfg.rows - DIM_CFG_W'(1));
	assign inner_m1 = IDX_W'(cfg.inner - DIM_CFG_W'(1));
	assign cols_m1  = IDX_W'(cfg.cols - DIM_CFG_W'(1));

	assign c_wrap = (c_q == cols_m1);
	assign k_wrap = (k_q == inner_m1);
	assign r_wrap = (r_q == rows_m1);

	// Load elements, then step the column fastest, inner next, row last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q  <= '0;
			rcnt_q  <= '0;
			run_q   <= 1'b0;
			r_q     <= '0;
			k_q     <= '0;
			c_q     <= '0;
			laddr_q <= '0;
			raddr_q <= '0;
		end else begin
			if (fire) begin
				if (done) begin
					lcnt_q  <= '0;
					rcnt_q  <= '0;
					run_q   <= 1'b1;
					r_q     <= '0;
					k_q     <= '0;
					c_q     <= '0;
					laddr_q <= '0;
					raddr_q <= '0;
				end else begin
					lcnt_q <= lcnt_nxt;
					rcnt_q <= rcnt_nxt;
				end
			end
			if (run_q && adv) begin
				if (c_wrap) begin
					c_q     <= '0;
					laddr_q <= laddr_q + ADDR_W'(1);
					if (k_wrap) begin
						k_q     <= '0;
						raddr_q <= '0;
						r_q     <= r_q + IDX_W'(1);
						if (r_wrap) begin
							run_q <= 1'b0;
						end
					end else begin
						k_q     <= k_q + IDX_W'(1);
						raddr_q <= raddr_q + ADDR_W'(1);
					end
				end else begin
					c_q     <= c_q + IDX_W'(1);
					raddr_q <= raddr_q + ADDR_W'(1);
				end
			end
		end
	end

	assign ready = !run_q && !drain_busy;
	assign laddr = laddr_q;
	assign raddr = raddr_q;

	// Describe the beat issued this cycle
	always_comb begin
		issue.valid = run_q;
		issue.first = (k_q == '0);
		issue.fin   = k_wrap;
		issue.last  = r_wrap && c_wrap;
		issue.row   = r_q;
		issue.col   = c_q;
	end

endmodule

// File: design/mm_cell.sv
// ----------------------------------------------------------------------------
// Matrix multiply accumulator cell
// One partial sum of the ring; takes its neighbor's sum on each beat.
// ----------------------------------------------------------------------------
module mm_cell #(
	parameter int W = 35
) (
	input  logic         clk,
	input  logic         en,
	input  logic         clr,
	input  logic         add,
	input  logic [W-1:0] sum_in,
	input  logic [W-1:0] addend,
	output logic [W-1:0] nxt,
	output logic [W-1:0] sum
);
	logic [W-1:0] sum_q;

	// Restart or carry the incoming sum, optionally adding the product
	assign nxt = (clr ? '0 : sum_in) + (add ? addend : '0);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_q <= nxt;
		end
	end

	assign sum = sum_q;

endmodule

// File: design/matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// Matrix multiply top level
// Loads two matrices and streams their exact fixed-point product.
// ----------------------------------------------------------------------------
// Usage: write left_rows, inner_size and right_cols over the APB port while
// idle. Send elements on the operand channel, one beat per cycle: operation 0
// for the next left element, 1 for the next right element, each in row-major
// order; surplus elements are dropped. The beat that completes both matrices
// starts the product. Results leave on the result channel in row-major order,
// the final one with last set. The product is computed by the single
// multiplier feeding a ring of right_cols accumulator cells, one
// multiply-accumulate per cycle while the result is not stalled; a result
// leaves once its last inner term is summed. operand.ready is low after the
// completing beat until the last result is registered.
// A stalled result freezes the whole multiply pipeline.
// Reset clears the element counts and sets every dimension to 1; the element
// stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_top #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mm_in_if.sink                         operand,
	mm_out_if.source                      result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mm_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready
);
	import mm_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int PROD_W = 2 * ELEM_BITS;
	localparam int EXT_W  = (PROD_W > PRODUCT_W) ? PROD_W : PRODUCT_W;
	localparam int VEXT_W = ELEM_BITS + VALUE_W;

	mm_cfg_t                     cfg;
	logic                        fire, adv, drain_busy;
	logic                        wr_left, wr_right;
	logic [ADDR_W-1:0]           wr_addr, laddr, raddr;
	mm_tok_t                     issue, tok_s1, tok_s2;
	logic signed [VEXT_W-1:0]    vext;
	logic signed [ELEM_BITS-1:0] elem;
	logic signed [ELEM_BITS-1:0] lmem [DEPTH];
	logic signed [ELEM_BITS-1:0] rmem [DEPTH];
	logic signed [ELEM_BITS-1:0] lrd_s1, rrd_s1;
	logic signed [PROD_W-1:0]    prod_s2;
	logic signed [EXT_W-1:0]     prod_ext;
	logic [PRODUCT_W-1:0]        prod35;
	logic [PRODUCT_W-1:0]        cell_q   [MAX_DIM];
	logic [PRODUCT_W-1:0]        cell_nxt [MAX_DIM];
	logic [PRODUCT_W-1:0]        tail;
	logic [DIM_W-1:0]            tail_idx;
	logic                        ring_en;
	logic                        out_valid_q;
	logic [PRODUCT_W-1:0]        product_q;
	logic [IDX_W-1:0]            row_q, col_q;
	logic                        last_q;

	mm_regs #(.MAX_DIM(MAX_DIM)) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign fire       = operand.valid && operand.ready;
	assign adv        = !out_valid_q || result.ready;
	assign drain_busy = tok_s1.valid || tok_s2.valid;

	mm_seq #(.ADDR_W(ADDR_W)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fire       (fire),
		.op         (operand.operation),
		.adv        (adv),
		.drain_busy (drain_busy),
		.ready      (operand.ready),
		.wr_left    (wr_left),
		.wr_right   (wr_right),
		.wr_addr    (wr_addr),
		.laddr      (laddr),
		.raddr      (raddr),
		.issue      (issue)
	);

	// Sign-extend the loaded value, keep the element width
	assign vext = VEXT_W'(operand.value);
	assign elem = vext[ELEM_BITS-1:0];

	// Element stores: written while loading, read while multiplying
	always_ff @(posedge clk) begin
		if (wr_left) begin
			lmem[wr_addr] <= elem;
		end
		if (wr_right) begin
			rmem[wr_addr] <= elem;
		end
		if (adv) begin
			lrd_s1 <= lmem[laddr];
			rrd_s1 <= rmem[raddr];
			prod_s2 <= lrd_s1 * rrd_s1;
		end
	end

	// Advance the beat tags alongside the read and multiply stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else if (adv) begin
			tok_s1 <= issue;
			tok_s2 <= tok_s1;
		end
	end

	assign prod_ext = EXT_W'(prod_s2);
	assign prod35   = prod_ext[PRODUCT_W-1:0];

	// Ring of partial sums, one per product column; its length is right_cols
	assign ring_en  = adv && tok_s2.valid;
	assign tail_idx = DIM_W'(cfg.cols - DIM_CFG_W'(1));
	assign tail     = cell_q[tail_idx];

	for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
		if (i == 0) begin : g_head
			mm_cell #(.W(PRODUCT_W)) u_cell (
				.clk    (clk),
				.en     (ring_en),
				.clr    (tok_s2.first),
				.add    (1'b1),
				.sum_in (tail),
				.addend (prod35),
				.nxt    (cell_nxt[i]),
				.sum    (cell_q[i])
			);
		end else begin : g_body
			mm_cell #(.W(PRODUCT_W)) u_cell (
				.clk    (clk),
				.en     (ring_en),
				.clr    (1'b0),
				.add    (1'b0),
				.sum_in (cell_q[i-1]),
				.addend (prod35),
				.nxt    (cell_nxt[i]),
				.sum    (cell_q[i])
			);
		end
	end

	// Hold the finished product until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tok_s2.valid && tok_s2.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok_s2.valid && tok_s2.fin) begin
			product_q <= cell_nxt[0];
			row_q     <= tok_s2.row;
			col_q     <= tok_s2.col;
			last_q    <= tok_s2.last;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.product = $signed(product_q);
	assign result.out_row = row_q;
	assign result.out_col = col_q;
	assign result.last    = last_q;

endmodule

// File: test/matrix_multiply_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix multiply testbench
// Programs the three dimensions over APB, streams left and right elements
// with random gaps, and checks every product element, its position and its
// last flag against a behavioral model of the multiplier.
// ----------------------------------------------------------------------------
module matrix_multiply_top_tb;
	import mm_pkg::*;

	localparam int          DIM_LIMIT    = 8;
	localparam int          STORE_DEPTH  = DIM_LIMIT * DIM_LIMIT;
	localparam int          RANDOM_ITEMS = 320;
	localparam int          IDLE_SETTLE  = 12;
	localparam int          DRAIN_CYCLES = 100;
	localparam int          CYCLE_LIMIT  = 10000000;
	localparam int          REPORT_LIMIT = 100;
	localparam logic [1:0]  REG_UNMAPPED = 2'd3;

	// One expected product element
	typedef struct packed {
		logic signed [PRODUCT_W-1:0] product;
		logic [IDX_W-1:0]            out_row;
		logic [IDX_W-1:0]            out_col;
		logic                        last;
	} product_elem_t;

	// Element content for one random phase
	typedef enum {
		FILL_RANDOM,
		FILL_RAILS,
		FILL_MIN,
		FILL_MIN_MAX
	} fill_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	mm_in_if  operand_ch();
	mm_out_if result_ch();

	matrix_multiply_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Multiplier model state
	logic signed [VALUE_W-1:0] left_mem [STORE_DEPTH];
	logic signed [VALUE_W-1:0] right_mem [STORE_DEPTH];
	int unsigned               left_cnt;
	int unsigned               right_cnt;
	int unsigned               dim_rows;
	int unsigned               dim_inner;
	int unsigned               dim_cols;

	product_elem_t product_queue[$];
	int unsigned   stored_elems;
	int unsigned   errors;
	int unsigned   cycle_count;
	bit            source_gaps;
	bit            sink_stalls;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Map a written dimension nibble into 1..DIM_LIMIT
	function automatic int unsigned fit_dim(input logic [DIM_CFG_W-1:0] raw);
		if (raw == '0) begin
			return 1;
		end
		if (raw > DIM_LIMIT) begin
			return DIM_LIMIT;
		end
		return 32'(raw);
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value(input fill_t fill, input logic op);
		int unsigned r;
		case (fill)
			FILL_RAILS: begin
				return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			end
			FILL_MIN: begin
				return 16'sh8000;
			end
			FILL_MIN_MAX: begin
				return (op == OP_LEFT) ? 16'sh8000 : 16'sh7FFF;
			end
			default: begin
				r = $urandom_range(0, 15);
				case (r)
					0: return 16'sh0000;
					1: return 16'sh0001;
					2: return 16'shFFFF;
					3: return 16'sh7FFF;
					4: return 16'sh8000;
					default: return VALUE_W'($urandom());
				endcase
			end
		endcase
	endfunction

	// Mostly small dimensions, a few at the limit, some out of range
	function automatic logic [APB_DATA_W-1:0] pick_dim_word();
		logic [APB_DATA_W-1:0] word;
		int unsigned           r;
		word = '0;
		if ($urandom_range(0, 3) == 0) begin
			word = $urandom();
		end
		r = $urandom_range(0, 99);
		if (r < 75) begin
			word[3:0] = 4'($urandom_range(1, 3));
		end else if (r < 88) begin
			word[3:0] = 4'($urandom_range(4, 7));
		end else if (r < 95) begin
			word[3:0] = 4'(DIM_LIMIT);
		end else begin
			word[3:0] = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
		end
		return word;
	endfunction

	task automatic reset_model();
		foreach (left_mem[i]) begin
			left_mem[i]  = '0;
			right_mem[i] = '0;
		end
		left_cnt  = 0;
		right_cnt = 0;
		dim_rows  = 1;
		dim_inner = 1;
		dim_cols  = 1;
	endtask

	// Store one element; on completion of both matrices queue the whole product
	task automatic load_element(input logic op, input logic signed [VALUE_W-1:0] v);
		int unsigned   need_left;
		int unsigned   need_right;
		longint        acc;
		product_elem_t elem;
		need_left  = dim_rows * dim_inner;
		need_right = dim_inner * dim_cols;
		if (op == OP_LEFT) begin
			if (left_cnt < need_left) begin
				left_mem[left_cnt] = v;
				left_cnt++;
				stored_elems++;
			end
		end else begin
			if (right_cnt < need_right) begin
				right_mem[right_cnt] = v;
				right_cnt++;
				stored_elems++;
			end
		end
		if (left_cnt < need_left || right_cnt < need_right) begin
			return;
		end
		for (int unsigned r = 0; r < dim_rows; r++) begin
			for (int unsigned c = 0; c < dim_cols; c++) begin
				acc = 0;
				for (int unsigned k = 0; k < dim_inner; k++) begin
					acc += longint'(left_mem[r * dim_inner + k]) *
						longint'(right_mem[k * dim_cols + c]);
				end
				elem.product = acc[PRODUCT_W-1:0];
				elem.out_row = IDX_W'(r);
				elem.out_col = IDX_W'(c);
				elem.last    = (r + 1 == dim_rows) && (c + 1 == dim_cols);
				product_queue.push_back(elem);
			end
		end
		left_cnt  = 0;
		right_cnt = 0;
	endtask

	// Send one element beat, holding valid until the block takes it
	task automatic send_elem(input logic op, input logic signed [VALUE_W-1:0] v);
		int unsigned gap;
		gap = source_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			operand_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operand_ch.valid     <= 1'b1;
		operand_ch.operation <= op;
		operand_ch.value     <= v;
		@(posedge clk);
		while (!operand_ch.ready) @(posedge clk);
		load_element(op, v);
	endtask

	// Drop valid and wait for every queued product plus a settle time
	task automatic wait_idle();
		operand_ch.valid <= 1'b0;
		@(posedge clk);
		while (product_queue.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_LEFT_ROWS:  dim_rows  = fit_dim(data[DIM_CFG_W-1:0]);
			REG_INNER_SIZE: dim_inner = fit_dim(data[DIM_CFG_W-1:0]);
			REG_RIGHT_COLS: dim_cols  = fit_dim(data[DIM_CFG_W-1:0]);
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [APB_DATA_W-1:0] rows_word,
		input logic [APB_DATA_W-1:0] inner_word, input logic [APB_DATA_W-1:0] cols_word);
		wait_idle();
		apb_write(REG_LEFT_ROWS, rows_word);
		apb_write(REG_INNER_SIZE, inner_word);
		apb_write(REG_RIGHT_COLS, cols_word);
	endtask

	// Default 1x1x1 dimensions after reset, either load order
	task automatic test_reset_dims();
		send_elem(OP_LEFT, 16'sh8000);
		send_elem(OP_RIGHT, 16'sh8000);
		send_elem(OP_RIGHT, 16'sh7FFF);
		send_elem(OP_LEFT, 16'shFFFF);
	endtask

	// Extra elements for an already complete matrix are dropped
	task automatic test_surplus();
		configure(32'd1, 32'd1, 32'd2);
		send_elem(OP_LEFT, 16'sh0100);
		send_elem(OP_LEFT, 16'sh7FFF);
		send_elem(OP_RIGHT, 16'sh0080);
		send_elem(OP_RIGHT, 16'sh8000);
	endtask

	// Zero and oversized dimensions clamp; the unmapped register is inert
	task automatic test_dim_clamp();
		configure(32'h5A5A_A5AF, 32'h0000_0000, 32'hABCD_0010);
		apb_write(REG_UNMAPPED, 32'h0000_0002);
		repeat (8) send_elem(OP_LEFT, pick_value(FILL_RANDOM, OP_LEFT));
		send_elem(OP_RIGHT, 16'sh8000);
	endtask

	// Shrink the dimensions mid-load; the next beat of any kind fires
	task automatic test_resize_midload();
		configure(32'd2, 32'd2, 32'd2);
		repeat (3) send_elem(OP_LEFT, pick_value(FILL_RANDOM, OP_LEFT));
		repeat (2) send_elem(OP_RIGHT, pick_value(FILL_RANDOM, OP_RIGHT));
		configure(32'd1, 32'd2, 32'd1);
		send_elem(OP_LEFT, pick_value(FILL_RANDOM, OP_LEFT));
	endtask

	// One matrix pair in random interleaving, sometimes cut short or with noise
	task automatic load_matrix_pair(input fill_t fill);
		int unsigned left_rem;
		int unsigned right_rem;
		int unsigned total;
		int unsigned cut;
		left_rem  = dim_rows * dim_inner;
		right_rem = dim_inner * dim_cols;
		total     = left_rem + right_rem;
		cut       = total;
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, total - 1);
		end
		for (int unsigned s = 0; s < cut; s++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_elem(1'($urandom_range(0, 1)), pick_value(FILL_RANDOM, OP_LEFT));
			end
			if (left_rem > 0 && (right_rem == 0 || $urandom_range(0, 1) == 1)) begin
				send_elem(OP_LEFT, pick_value(fill, OP_LEFT));
				left_rem--;
			end else begin
				send_elem(OP_RIGHT, pick_value(fill, OP_RIGHT));
				right_rem--;
			end
		end
	endtask

	// Random phases: new dimensions, then one to three matrix pairs
	task automatic test_random_traffic();
		int unsigned start_count;
		int unsigned phase;
		int unsigned r;
		fill_t       fill;
		start_count = stored_elems;
		phase       = 0;
		while (stored_elems - start_count < RANDOM_ITEMS) begin
			source_gaps = ($urandom_range(0, 3) != 0);
			sink_stalls = ($urandom_range(0, 3) != 0);
			if (phase < 2) begin
				// full-scale sums over the longest inner dimension
				fill = (phase == 0) ? FILL_MIN : FILL_MIN_MAX;
				configure(32'd1, DIM_LIMIT, 32'd1);
			end else begin
				r = $urandom_range(0, 19);
				fill = (r < 14) ? FILL_RANDOM : (r < 18) ? FILL_RAILS :
					(r == 18) ? FILL_MIN : FILL_MIN_MAX;
				configure(pick_dim_word(), pick_dim_word(), pick_dim_word());
				if ($urandom_range(0, 9) == 0) begin
					apb_write(REG_UNMAPPED, $urandom());
				end
			end
			repeat ($urandom_range(1, 3)) begin
				if (stored_elems - start_count < RANDOM_ITEMS) begin
					load_matrix_pair(fill);
				end
			end
			phase++;
		end
	endtask

	task automatic report_mismatch(input string field, input longint want_v,
		input longint got_v);
		errors++;
		if (errors <= REPORT_LIMIT) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
		end
	endtask

	// Compare each accepted product beat with the oldest expectation
	always @(posedge clk) begin : check_products
		product_elem_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (product_queue.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$error("unexpected product beat at row %0d col %0d",
						result_ch.out_row, result_ch.out_col);
				end
			end else begin
				want = product_queue.pop_front();
				if (result_ch.product !== want.product) begin
					report_mismatch("product", longint'(want.product),
						longint'(result_ch.product));
				end
				if (result_ch.out_row !== want.out_row) begin
					report_mismatch("out_row", longint'(want.out_row),
						longint'(result_ch.out_row));
				end
				if (result_ch.out_col !== want.out_col) begin
					report_mismatch("out_col", longint'(want.out_col),
						longint'(result_ch.out_col));
				end
				if (result_ch.last !== want.last) begin
					report_mismatch("last", longint'(want.last), longint'(result_ch.last));
				end
			end
		end
	end

	// Stall the result channel in bursts when enabled
	initial begin
		int unsigned open_len;
		int unsigned stall_len;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!sink_stalls) begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				open_len  = $urandom_range(1, 8);
				stall_len = pick_gap() + 1;
				result_ch.ready <= 1'b1;
				repeat (open_len) @(posedge clk);
				result_ch.ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// Bound the run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n               <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		operand_ch.valid     <= 1'b0;
		operand_ch.operation <= OP_LEFT;
		operand_ch.value     <= '0;
		errors       = 0;
		cycle_count  = 0;
		stored_elems = 0;
		source_gaps  = 1'b1;
		sink_stalls  = 1'b1;
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_dims();
		test_surplus();
		test_dim_clamp();
		test_resize_midload();
		test_random_traffic();

		// drain outstanding products, then watch for strays
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && product_queue.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
design/mm_pkg.sv
design/mm_if.sv
design/mm_regs.sv
design/mm_seq.sv
design/mm_cell.sv
design/matrix_multiply_top.sv
test/matrix_multiply_top_tb.sv
